### hw/rtl/mwmt_pkg.sv
// ----------------------------------------------------------------------------
// Maze wall map tracker package
// Grid size, field layouts, mode and slot codes, and the control and status
// bundles shared between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package mwmt_pkg;

  // Grid size; both dimensions stay within 2 to 16 so a coordinate fits 4 bits.
  localparam int GRID_WIDTH  = 16;
  localparam int GRID_HEIGHT = 16;

  // Map storage: one entry per cell of the largest grid.
  localparam int CELLS  = 256;
  localparam int ADDR_W = $clog2(CELLS);

  typedef logic [ADDR_W-1:0] addr_t;

  // Grid limits at the width of the request coordinates.
  localparam logic [7:0] GRID_W_LIM = 8'(GRID_WIDTH);
  localparam logic [7:0] GRID_H_LIM = 8'(GRID_HEIGHT);

  // Item modes.
  typedef enum logic [2:0] {
    MODE_RESET_POSE = 3'd0,
    MODE_ADVANCE    = 3'd1,
    MODE_TURN       = 3'd2,
    MODE_MAP        = 3'd3,
    MODE_SPECIAL    = 3'd4,
    MODE_QUERY      = 3'd5
  } mode_e;

  // Headings, clockwise from north.
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // Read-modify-write slots: the current cell, then the sensed neighbors.
  localparam logic [1:0] SLOT_CELL  = 2'd0;
  localparam logic [1:0] SLOT_FRONT = 2'd1;
  localparam logic [1:0] SLOT_RIGHT = 2'd2;
  localparam logic [1:0] SLOT_LEFT  = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEADING = 2'd2;

  // One request item.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [1:0] direction;
    logic [1:0] turn_quarters;
    logic       front_wall;
    logic       right_wall;
    logic       left_wall;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic       ok;
    logic [3:0] pose_x;
    logic [3:0] pose_y;
    logic [1:0] pose_heading;
    logic       is_visited;
    logic       is_special;
    logic [3:0] cell_walls;
    logic [3:0] cell_known;
    logic       edge_open;
    logic       neighbor_valid;
    logic [3:0] nbr_x;
    logic [3:0] nbr_y;
  } out_item_t;

  // One map entry; walls and known edges use bit 0 north to bit 3 west.
  typedef struct packed {
    logic [3:0] known;
    logic       special;
    logic       visited;
    logic [3:0] walls;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer commands to the datapath.
  typedef struct packed {
    logic       latch;
    logic       exec;
    logic       rmw;
    logic       report;
    logic       load;
    logic [1:0] slot;
  } cmd_t;

  // Datapath status to the sequencer.
  typedef struct packed {
    logic [2:0] mode;
    logic       out_busy;
  } sts_t;

endpackage

### hw/rtl/mwmt_in_if.sv
// ----------------------------------------------------------------------------
// Maze wall map tracker request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface mwmt_in_if;
  logic                valid;
  logic                ready;
  mwmt_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/mwmt_out_if.sv
// ----------------------------------------------------------------------------
// Maze wall map tracker result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface mwmt_out_if;
  logic                valid;
  logic                ready;
  mwmt_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### hw/rtl/mwmt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mwmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mwmt_ctrl.sv
// ----------------------------------------------------------------------------
// Maze wall map tracker sequencer
// Steps each item through execute, cell read-modify-write (map and special items
// only), report read and result load, and tells the datapath what to do in each cycle.
// ----------------------------------------------------------------------------
module mwmt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mwmt_pkg::sts_t sts_i,
  output mwmt_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_EXEC    = 5'b00010,
    ST_RMW     = 5'b00100,
    ST_REPORT  = 5'b01000,
    ST_CAPTURE = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] slot_q, slot_d;
  logic [1:0] last_slot;
  logic       needs_rmw;

  // Map mode touches the cell and three neighbors; special mode only the cell.
  assign needs_rmw = (sts_i.mode == mwmt_pkg::MODE_MAP) ||
                     (sts_i.mode == mwmt_pkg::MODE_SPECIAL);
  assign last_slot = (sts_i.mode == mwmt_pkg::MODE_MAP) ? mwmt_pkg::SLOT_LEFT
                                                        : mwmt_pkg::SLOT_CELL;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    cmd_o      = '0;
    cmd_o.slot = slot_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        slot_d     = mwmt_pkg::SLOT_CELL;
        state_d    = needs_rmw ? ST_RMW : ST_REPORT;
      end
      ST_RMW: begin
        cmd_o.rmw = 1'b1;
        if (slot_q == last_slot) begin
          slot_d  = mwmt_pkg::SLOT_CELL;
          state_d = ST_REPORT;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        // Wait here while the previous result is still in the output register.
        if (!sts_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and slot registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= mwmt_pkg::SLOT_CELL;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  // The slot counter only moves during the read-modify-write sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RMW) |-> (slot_q == mwmt_pkg::SLOT_CELL))
    else $error("slot counter left nonzero outside the read-modify-write sweep");

  // An accepted item always goes straight to execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("accepted item did not enter execution");

endmodule

### hw/rtl/mwmt_dp.sv
// ----------------------------------------------------------------------------
// Maze wall map tracker datapath
// Holds the pose, the start registers, the map RAM with per-cell valid flags,
// the cell update logic and the result register.
// ----------------------------------------------------------------------------
module mwmt_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mwmt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mwmt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  mwmt_pkg::in_item_t                  in_item_i,
  input  mwmt_pkg::cmd_t                      cmd_i,
  output mwmt_pkg::sts_t                      sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output mwmt_pkg::out_item_t                 out_item_o
);

  typedef struct packed {
    logic       valid;
    logic [3:0] x;
    logic [3:0] y;
  } nbr_t;

  // True when a request coordinate lies inside the grid.
  function automatic logic in_grid(logic [7:0] x, logic [7:0] y);
    return (x < mwmt_pkg::GRID_W_LIM) && (y < mwmt_pkg::GRID_H_LIM);
  endfunction

  // Map address of an in-grid cell.
  function automatic mwmt_pkg::addr_t addr_of(logic [3:0] x, logic [3:0] y);
    return mwmt_pkg::addr_t'(int'(y) * mwmt_pkg::GRID_WIDTH + int'(x));
  endfunction

  // Neighbor of an in-grid cell; at the border it is invalid and stays put.
  function automatic nbr_t step_cell(logic [3:0] x, logic [3:0] y, logic [1:0] d);
    nbr_t r;
    r.valid = 1'b0;
    r.x     = x;
    r.y     = y;
    case (d)
      mwmt_pkg::DIR_NORTH: begin
        if ((8'(y) + 8'd1) < mwmt_pkg::GRID_H_LIM) begin
          r.valid = 1'b1;
          r.y     = y + 4'd1;
        end
      end
      mwmt_pkg::DIR_EAST: begin
        if ((8'(x) + 8'd1) < mwmt_pkg::GRID_W_LIM) begin
          r.valid = 1'b1;
          r.x     = x + 4'd1;
        end
      end
      mwmt_pkg::DIR_SOUTH: begin
        if (y != 4'd0) begin
          r.valid = 1'b1;
          r.y     = y - 4'd1;
        end
      end
      default: begin
        if (x != 4'd0) begin
          r.valid = 1'b1;
          r.x     = x - 4'd1;
        end
      end
    endcase
    return r;
  endfunction

  // Direction of the edge sensed in a given slot, relative to heading h.
  function automatic logic [1:0] slot_dir(logic [1:0] slot, logic [1:0] h);
    logic [1:0] d;
    case (slot)
      mwmt_pkg::SLOT_RIGHT: d = h + 2'd1;
      mwmt_pkg::SLOT_LEFT:  d = h + 2'd3;
      default:              d = h;
    endcase
    return d;
  endfunction

  function automatic logic [3:0] dir_mask(logic [1:0] d);
    return 4'b0001 << d;
  endfunction

  // Configuration and pose registers.
  logic [3:0] start_x_q, start_y_q;
  logic [1:0] start_h_q;
  logic [3:0] px_q, px_d, py_q, py_d;
  logic [1:0] ph_q, ph_d;

  // Item, status flag and result registers.
  mwmt_pkg::in_item_t  item_q;
  logic                ok_q, ok_d;
  mwmt_pkg::out_item_t out_q, out_d;
  logic                out_valid_q;

  // Map storage and per-cell valid flags.
  logic [mwmt_pkg::CELLS-1:0]   vld_q;
  logic                         rd_vld_q;
  logic                         ram_we, ram_re;
  mwmt_pkg::addr_t              ram_waddr, ram_raddr;
  logic [mwmt_pkg::ENTRY_W-1:0] ram_rdata;
  mwmt_pkg::entry_t             rd_entry, upd_entry;

  // Address and neighbor helpers.
  mwmt_pkg::addr_t cur_addr, rep_addr;
  nbr_t            adv_nb, wr_nb, nx_nb, q_nb;
  logic [1:0]      wr_dir, wr_opp, nx_slot;
  logic            wr_wall, q_in, is_map, is_query, nb_ok;

  assign is_map   = (item_q.mode == mwmt_pkg::MODE_MAP);
  assign is_query = (item_q.mode == mwmt_pkg::MODE_QUERY);
  assign cur_addr = addr_of(px_q, py_q);
  assign adv_nb   = step_cell(px_q, py_q, ph_q);

  assign sts_o.mode     = item_q.mode;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      start_h_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mwmt_pkg::CFG_START_X:       start_x_q <= cfg_data_i;
        mwmt_pkg::CFG_START_Y:       start_y_q <= cfg_data_i;
        mwmt_pkg::CFG_START_HEADING: start_h_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Pose update in the execute cycle.
  always_comb begin
    px_d = px_q;
    py_d = py_q;
    ph_d = ph_q;
    if (cmd_i.exec) begin
      unique case (item_q.mode)
        mwmt_pkg::MODE_RESET_POSE: begin
          if (in_grid(item_q.cell_x, item_q.cell_y)) begin
            px_d = item_q.cell_x[3:0];
            py_d = item_q.cell_y[3:0];
            ph_d = item_q.direction;
          end else if (in_grid({4'b0, start_x_q}, {4'b0, start_y_q})) begin
            px_d = start_x_q;
            py_d = start_y_q;
            ph_d = start_h_q;
          end
        end
        mwmt_pkg::MODE_ADVANCE: begin
          if (adv_nb.valid) begin
            px_d = adv_nb.x;
            py_d = adv_nb.y;
          end
        end
        mwmt_pkg::MODE_TURN: begin
          ph_d = ph_q + item_q.turn_quarters;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      ph_q <= '0;
    end else begin
      px_q <= px_d;
      py_q <= py_d;
      ph_q <= ph_d;
    end
  end

  // Entry read back from the map; a cell not written since the last clear is zero.
  assign rd_entry = rd_vld_q ? mwmt_pkg::entry_t'(ram_rdata) : '0;

  // Slot being written and the slot read ahead of it.
  assign wr_dir  = slot_dir(cmd_i.slot, ph_q);
  assign wr_opp  = wr_dir + 2'd2;
  assign wr_nb   = step_cell(px_q, py_q, wr_dir);
  assign nx_slot = cmd_i.slot + 2'd1;
  assign nx_nb   = step_cell(px_q, py_q, slot_dir(nx_slot, ph_q));

  always_comb begin
    case (cmd_i.slot)
      mwmt_pkg::SLOT_FRONT: wr_wall = item_q.front_wall;
      mwmt_pkg::SLOT_RIGHT: wr_wall = item_q.right_wall;
      mwmt_pkg::SLOT_LEFT:  wr_wall = item_q.left_wall;
      default:              wr_wall = 1'b0;
    endcase
  end

  // Cell update for the current slot.
  always_comb begin
    upd_entry = rd_entry;
    ok_d      = ok_q;
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    if (cmd_i.exec) begin
      ok_d = (item_q.mode == mwmt_pkg::MODE_RESET_POSE) &&
             in_grid(item_q.cell_x, item_q.cell_y);
    end
    if (cmd_i.rmw) begin
      if (cmd_i.slot == mwmt_pkg::SLOT_CELL) begin
        if (is_map) begin
          // Front, right and left edges become known; walls as sensed.
          upd_entry.known   = rd_entry.known | dir_mask(ph_q) |
                              dir_mask(ph_q + 2'd1) | dir_mask(ph_q + 2'd3);
          upd_entry.walls   = rd_entry.walls |
                              (item_q.front_wall ? dir_mask(ph_q) : 4'b0) |
                              (item_q.right_wall ? dir_mask(ph_q + 2'd1) : 4'b0) |
                              (item_q.left_wall  ? dir_mask(ph_q + 2'd3) : 4'b0);
          upd_entry.visited = 1'b1;
          ram_we            = 1'b1;
        end else begin
          // Mark special only when the flag is not yet set.
          upd_entry.visited = 1'b1;
          upd_entry.special = 1'b1;
          ram_we            = !rd_entry.special;
          ok_d              = !rd_entry.special;
        end
      end else begin
        // Mirror the sensed edge into the neighbor, seen from its side.
        upd_entry.known = rd_entry.known | dir_mask(wr_opp);
        upd_entry.walls = rd_entry.walls | (wr_wall ? dir_mask(wr_opp) : 4'b0);
        ram_we          = wr_nb.valid;
        ram_waddr       = addr_of(wr_nb.x, wr_nb.y);
      end
    end
  end

  // Read port: current cell at execute, next neighbor during the sweep,
  // report cell at the end.
  assign rep_addr = is_query ? addr_of(item_q.cell_x[3:0], item_q.cell_y[3:0]) : cur_addr;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = cur_addr;
    if (cmd_i.exec) begin
      ram_re = 1'b1;
    end else if (cmd_i.rmw) begin
      ram_re    = is_map && (cmd_i.slot != mwmt_pkg::SLOT_LEFT) && nx_nb.valid;
      ram_raddr = addr_of(nx_nb.x, nx_nb.y);
    end else if (cmd_i.report) begin
      ram_re    = 1'b1;
      ram_raddr = rep_addr;
    end
  end

  mwmt_ram #(
    .WIDTH (mwmt_pkg::ENTRY_W),
    .DEPTH (mwmt_pkg::CELLS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (upd_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Per-cell valid flags: a pose reset clears the whole map at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.exec && (item_q.mode == mwmt_pkg::MODE_RESET_POSE)) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[ram_waddr] <= 1'b1;
    end
  end

  // Item, read flag and status flag registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_item_i;
    end
    if (ram_re) begin
      rd_vld_q <= vld_q[ram_raddr];
    end
    ok_q <= ok_d;
  end

  // Result assembly from the report read.
  assign q_in = in_grid(item_q.cell_x, item_q.cell_y);
  assign q_nb = step_cell(item_q.cell_x[3:0], item_q.cell_y[3:0], item_q.direction);
  assign nb_ok = q_in && q_nb.valid;

  always_comb begin
    out_d                = '0;
    out_d.pose_x         = px_q;
    out_d.pose_y         = py_q;
    out_d.pose_heading   = ph_q;
    if (is_query) begin
      out_d.ok = q_in;
      if (q_in) begin
        out_d.is_visited = rd_entry.visited;
        out_d.is_special = rd_entry.special;
        out_d.cell_walls = rd_entry.walls;
        out_d.cell_known = rd_entry.known;
      end
      if (nb_ok) begin
        out_d.neighbor_valid = 1'b1;
        out_d.nbr_x          = q_nb.x;
        out_d.nbr_y          = q_nb.y;
        out_d.edge_open      = rd_entry.known[item_q.direction] &&
                               !rd_entry.walls[item_q.direction];
      end
    end else begin
      out_d.ok         = ok_q;
      out_d.is_visited = rd_entry.visited;
      out_d.is_special = rd_entry.special;
      out_d.cell_walls = rd_entry.walls;
      out_d.cell_known = rd_entry.known;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The sweep never reads the cell it writes in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("map RAM read and write collide on one address");

  // A result appears only when the sequencer loads one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load))
    else $error("result valid rose without a load");

endmodule

### hw/rtl/maze_wall_map_tracker.sv
// Sequence: each accepted item is executed, then map sweeps the cell and its three
// sensed neighbors, and mark special the cell alone, through the map RAM's one write
// port; the report cell is then read and the result loaded. Throughput: one item at
// a time, the next accepted the cycle after the load; an unread result stalls the load.
// Reset: pose and start registers go to zero and per-cell flags clear the map
// at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Maze wall map tracker
// Grid map of maze walls, known edges and cell flags, with a robot pose.
// ----------------------------------------------------------------------------
module maze_wall_map_tracker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mwmt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mwmt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mwmt_in_if.sink                         in_i,
  mwmt_out_if.source                      res_o
);

  mwmt_pkg::cmd_t cmd;
  mwmt_pkg::sts_t sts;

  // Sequencer.
  mwmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with the map RAM and result register.
  mwmt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_i.item),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .out_item_o  (res_o.item)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze wall map tracker testbench
// Drives pose, turn, map, special and query items through the request channel
// and checks every result against a cycle-free model of the map and the pose.
// The sender works in random bursts and the receiver stalls on its own
// pattern, with calm phases in between. Start registers are rewritten between
// phases, including their extremes.
// ----------------------------------------------------------------------------
module tb_top;
  import mwmt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 420;

  // Map entry flag bits above the four wall bits.
  localparam logic [5:0] VISITED_FLAG = 6'h10;
  localparam logic [5:0] SPECIAL_FLAG = 6'h20;

  // Mode codes the block does not use; they must leave everything alone.
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mwmt_in_if  req_if ();
  mwmt_out_if res_if ();

  maze_wall_map_tracker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_if),
    .res_o      (res_if)
  );

  // Model of the map, the robot pose and the start registers.
  logic [5:0] map_cell [CELLS];
  logic [3:0] map_known [CELLS];
  logic [3:0] pose_x;
  logic [3:0] pose_y;
  logic [1:0] pose_dir;
  logic [3:0] start_x;
  logic [3:0] start_y;
  logic [1:0] start_dir;

  out_item_t expected_results[$];
  out_item_t oldest_expected;
  int        mismatch_count;
  int        result_count;
  int        cycle_count;

  // Traffic shaping controls.
  logic        gaps_on;
  logic        stall_on;
  int          burst_left;
  logic [15:0] stall_pattern;
  logic [3:0]  stall_pos;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit in case the block hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("maze_wall_map_tracker verification failed");
    $finish;
  end

  // Receiver: ready follows a rotating pattern that is reloaded now and then.
  initial begin
    res_if.ready  = 1'b0;
    stall_pattern = 16'hffff;
    stall_pos     = '0;
    forever begin
      @(negedge clk_i);
      if (stall_on) begin
        res_if.ready = stall_pattern[stall_pos];
      end else begin
        res_if.ready = 1'b1;
      end
      stall_pos = stall_pos + 4'd1;
      if (stall_pos == 4'd0) begin
        stall_pattern = 16'($urandom) | 16'h0201;
      end
    end
  end

  // Model helpers.
  function automatic void clear_map();
    for (int i = 0; i < CELLS; i++) begin
      map_cell[addr_t'(i)]  = '0;
      map_known[addr_t'(i)] = '0;
    end
  endfunction

  function automatic logic in_grid(logic [7:0] x, logic [7:0] y);
    return (x < GRID_W_LIM) && (y < GRID_H_LIM);
  endfunction

  function automatic addr_t cell_addr(logic [3:0] x, logic [3:0] y);
    return addr_t'(int'(y) * GRID_WIDTH + int'(x));
  endfunction

  // Neighbor of an in-grid cell; returns 0 at the border.
  function automatic logic neighbor_of(input logic [3:0] x, input logic [3:0] y,
                                       input logic [1:0] d, output logic [3:0] nx,
                                       output logic [3:0] ny);
    nx = x;
    ny = y;
    case (d)
      DIR_NORTH: begin
        if (int'(y) + 1 >= GRID_HEIGHT) return 1'b0;
        ny = y + 4'd1;
      end
      DIR_EAST: begin
        if (int'(x) + 1 >= GRID_WIDTH) return 1'b0;
        nx = x + 4'd1;
      end
      DIR_SOUTH: begin
        if (y == 4'd0) return 1'b0;
        ny = y - 4'd1;
      end
      default: begin
        if (x == 4'd0) return 1'b0;
        nx = x - 4'd1;
      end
    endcase
    return 1'b1;
  endfunction

  // One sensed edge of the current cell, mirrored into an in-grid neighbor.
  function automatic void sense_edge(logic [1:0] d, logic wall);
    logic [3:0] nx;
    logic [3:0] ny;
    logic [1:0] back;
    addr_t      a;
    addr_t      b;
    a    = cell_addr(pose_x, pose_y);
    back = d + 2'd2;
    map_known[a][d] = 1'b1;
    if (wall) map_cell[a][d] = 1'b1;
    if (neighbor_of(pose_x, pose_y, d, nx, ny)) begin
      b = cell_addr(nx, ny);
      map_known[b][back] = 1'b1;
      if (wall) map_cell[b][back] = 1'b1;
    end
  endfunction

  // Applies one item to the model and returns the result it must produce.
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t  r;
    addr_t      a;
    logic [3:0] nx;
    logic [3:0] ny;
    logic       report_current;
    r = '0;
    report_current = 1'b1;
    case (it.mode)
      MODE_RESET_POSE: begin
        clear_map();
        if (in_grid(it.cell_x, it.cell_y)) begin
          pose_x   = it.cell_x[3:0];
          pose_y   = it.cell_y[3:0];
          pose_dir = it.direction;
          r.ok     = 1'b1;
        end else if (in_grid({4'd0, start_x}, {4'd0, start_y})) begin
          pose_x   = start_x;
          pose_y   = start_y;
          pose_dir = start_dir;
        end
      end
      MODE_ADVANCE: begin
        if (neighbor_of(pose_x, pose_y, pose_dir, nx, ny)) begin
          pose_x = nx;
          pose_y = ny;
        end
      end
      MODE_TURN: begin
        pose_dir = pose_dir + it.turn_quarters;
      end
      MODE_MAP: begin
        sense_edge(pose_dir, it.front_wall);
        sense_edge(pose_dir + 2'd1, it.right_wall);
        sense_edge(pose_dir + 2'd3, it.left_wall);
        a = cell_addr(pose_x, pose_y);
        map_cell[a] = map_cell[a] | VISITED_FLAG;
      end
      MODE_SPECIAL: begin
        a = cell_addr(pose_x, pose_y);
        if ((map_cell[a] & SPECIAL_FLAG) == '0) begin
          map_cell[a] = map_cell[a] | VISITED_FLAG | SPECIAL_FLAG;
          r.ok = 1'b1;
        end
      end
      MODE_QUERY: begin
        report_current = 1'b0;
        if (in_grid(it.cell_x, it.cell_y)) begin
          a = cell_addr(it.cell_x[3:0], it.cell_y[3:0]);
          r.ok         = 1'b1;
          r.cell_walls = map_cell[a][3:0];
          r.is_visited = map_cell[a][4];
          r.is_special = map_cell[a][5];
          r.cell_known = map_known[a];
          if (neighbor_of(it.cell_x[3:0], it.cell_y[3:0], it.direction, nx, ny)) begin
            r.neighbor_valid = 1'b1;
            r.nbr_x          = nx;
            r.nbr_y          = ny;
            r.edge_open      = map_known[a][it.direction] && !map_cell[a][it.direction];
          end
        end
      end
      default: ;
    endcase
    if (report_current) begin
      a = cell_addr(pose_x, pose_y);
      r.cell_walls = map_cell[a][3:0];
      r.is_visited = map_cell[a][4];
      r.is_special = map_cell[a][5];
      r.cell_known = map_known[a];
    end
    r.pose_x       = pose_x;
    r.pose_y       = pose_y;
    r.pose_heading = pose_dir;
    return r;
  endfunction

  // Item construction.
  function automatic in_item_t make_item(logic [2:0] mode, logic [7:0] x, logic [7:0] y,
                                         logic [1:0] d, logic [1:0] turn,
                                         logic [2:0] walls);
    in_item_t it;
    it.mode          = mode;
    it.cell_x        = x;
    it.cell_y        = y;
    it.direction     = d;
    it.turn_quarters = turn;
    it.front_wall    = walls[2];
    it.right_wall    = walls[1];
    it.left_wall     = walls[0];
    return it;
  endfunction

  // Mostly a robot exploring the maze; rare resets and spare modes.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    it   = in_item_t'(26'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 3) it.mode = MODE_RESET_POSE;
    else if (pick < 28) it.mode = MODE_ADVANCE;
    else if (pick < 46) it.mode = MODE_TURN;
    else if (pick < 70) it.mode = MODE_MAP;
    else if (pick < 78) it.mode = MODE_SPECIAL;
    else if (pick < 97) it.mode = MODE_QUERY;
    else if (pick < 98) it.mode = MODE_SPARE_6;
    else it.mode = MODE_SPARE_7;
    // Most coordinates land in or just beyond the grid.
    if ($urandom_range(0, 3) != 0) begin
      it.cell_x = 8'($urandom_range(0, 17));
      it.cell_y = 8'($urandom_range(0, 17));
    end
    return it;
  endfunction

  // Presents one item, with a random gap whenever a burst runs out and gaps are on.
  task automatic send_item(input in_item_t it);
    int gap;
    @(negedge clk_i);
    if (gaps_on && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 10);
    end
    req_if.valid = 1'b1;
    req_if.item  = it;
    burst_left--;
    do @(posedge clk_i); while (!req_if.ready);
    expected_results.push_back(predict_result(it));
  endtask

  // Stops sending and waits until every result is in and the block is quiet.
  task automatic wait_idle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_START_X: start_x = data;
      CFG_START_Y: start_y = data;
      CFG_START_HEADING: start_dir = data[1:0];
      default: ;
    endcase
  endtask

  task automatic write_start(logic [3:0] x, logic [3:0] y, logic [1:0] d);
    write_reg(CFG_START_X, x);
    write_reg(CFG_START_Y, y);
    write_reg(CFG_START_HEADING, {2'b00, d});
  endtask

  // Every mode at least once, plus border clamps, mirroring and out-of-grid queries.
  task automatic test_directed_modes();
    send_item(make_item(MODE_RESET_POSE, 8'd15, 8'd15, DIR_WEST, 2'd0, 3'b000));
    send_item(make_item(MODE_ADVANCE, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_TURN, 8'd0, 8'd0, DIR_NORTH, 2'd1, 3'b000));
    // Advance north from the top row must stay put.
    send_item(make_item(MODE_ADVANCE, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_MAP, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b101));
    send_item(make_item(MODE_SPECIAL, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    // A second mark on the same cell reports nothing new.
    send_item(make_item(MODE_SPECIAL, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_QUERY, 8'd14, 8'd15, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_QUERY, 8'd14, 8'd15, DIR_EAST, 2'd0, 3'b000));
    send_item(make_item(MODE_QUERY, 8'd14, 8'd15, DIR_WEST, 2'd0, 3'b000));
    send_item(make_item(MODE_QUERY, 8'd15, 8'd15, DIR_WEST, 2'd0, 3'b000));
    send_item(make_item(MODE_QUERY, 8'd255, 8'd255, DIR_SOUTH, 2'd3, 3'b111));
    send_item(make_item(MODE_QUERY, 8'd16, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_QUERY, 8'd0, 8'd16, DIR_EAST, 2'd0, 3'b000));
    send_item(make_item(MODE_SPARE_6, 8'd255, 8'd255, DIR_WEST, 2'd3, 3'b111));
    send_item(make_item(MODE_SPARE_7, 8'd3, 8'd4, DIR_SOUTH, 2'd2, 3'b010));
    // Invalid pose falls back to the start registers, still zero here.
    send_item(make_item(MODE_RESET_POSE, 8'd200, 8'd3, DIR_EAST, 2'd0, 3'b000));
    send_item(make_item(MODE_TURN, 8'd0, 8'd0, DIR_NORTH, 2'd2, 3'b000));
    send_item(make_item(MODE_ADVANCE, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_TURN, 8'd0, 8'd0, DIR_NORTH, 2'd1, 3'b000));
    send_item(make_item(MODE_ADVANCE, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    // Corner cell: two of the sensed edges have no neighbor to mirror into.
    send_item(make_item(MODE_MAP, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b111));
    send_item(make_item(MODE_QUERY, 8'd0, 8'd0, DIR_SOUTH, 2'd0, 3'b000));
  endtask

  // Start registers at their top values, then used by an invalid pose.
  task automatic test_start_fallback();
    wait_idle();
    write_start(4'd15, 4'd15, DIR_WEST);
    send_item(make_item(MODE_RESET_POSE, 8'd16, 8'd16, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_ADVANCE, 8'd0, 8'd0, DIR_NORTH, 2'd0, 3'b000));
    send_item(make_item(MODE_RESET_POSE, 8'd5, 8'd255, DIR_SOUTH, 2'd0, 3'b000));
  endtask

  // One phase of random exploration under a given start setting and traffic.
  task automatic test_random_walk(logic [3:0] x, logic [3:0] y, logic [1:0] d,
                                  logic idle_sides);
    wait_idle();
    write_start(x, y, d);
    gaps_on  = idle_sides;
    stall_on = idle_sides;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      send_item(random_item());
    end
  endtask

  // Compares one field and reports the first few differences.
  function automatic void check_field(string field_name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result %0d: %s expected %0h, got %0h", result_count, field_name,
                 want, got);
      end
    end
  endfunction

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result %0d arrived with nothing expected: %p", result_count,
                   res_if.item);
        end
      end else begin
        oldest_expected = expected_results.pop_front();
        check_field("ok", 32'(oldest_expected.ok), 32'(res_if.item.ok));
        check_field("pose_x", 32'(oldest_expected.pose_x), 32'(res_if.item.pose_x));
        check_field("pose_y", 32'(oldest_expected.pose_y), 32'(res_if.item.pose_y));
        check_field("pose_heading", 32'(oldest_expected.pose_heading),
                    32'(res_if.item.pose_heading));
        check_field("is_visited", 32'(oldest_expected.is_visited),
                    32'(res_if.item.is_visited));
        check_field("is_special", 32'(oldest_expected.is_special),
                    32'(res_if.item.is_special));
        check_field("cell_walls", 32'(oldest_expected.cell_walls),
                    32'(res_if.item.cell_walls));
        check_field("cell_known", 32'(oldest_expected.cell_known),
                    32'(res_if.item.cell_known));
        check_field("edge_open", 32'(oldest_expected.edge_open),
                    32'(res_if.item.edge_open));
        check_field("neighbor_valid", 32'(oldest_expected.neighbor_valid),
                    32'(res_if.item.neighbor_valid));
        check_field("nbr_x", 32'(oldest_expected.nbr_x), 32'(res_if.item.nbr_x));
        check_field("nbr_y", 32'(oldest_expected.nbr_y), 32'(res_if.item.nbr_y));
      end
    end
  end

  // Test sequence.
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_START_X;
    cfg_data_i     = '0;
    req_if.valid   = 1'b0;
    req_if.item    = '0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    burst_left     = 0;
    mismatch_count = 0;
    result_count   = 0;
    clear_map();
    pose_x    = '0;
    pose_y    = '0;
    pose_dir  = DIR_NORTH;
    start_x   = '0;
    start_y   = '0;
    start_dir = DIR_NORTH;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_modes();
    test_start_fallback();
    test_random_walk(4'd0, 4'd0, DIR_NORTH, 1'b1);
    test_random_walk(4'd15, 4'd15, DIR_WEST, 1'b0);
    test_random_walk(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     2'($urandom_range(0, 3)), 1'b1);
    test_random_walk(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                     2'($urandom_range(0, 3)), 1'b1);
    wait_idle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("maze_wall_map_tracker verification clean");
    end else begin
      $display("maze_wall_map_tracker verification failed");
    end
    $finish;
  end

endmodule
